@@ rtl/lm4n_pkg.sv @@
// shared types and constants of the 4-neighbour local maximum marker
package lm4n_pkg;

	// default geometry and sample format
	localparam int DEF_MAX_WIDTH   = 32;
	localparam int DEF_SAMPLE_BITS = 16;

	// configuration register file
	localparam int IMG_W_BITS = 6;
	localparam int IMG_H_BITS = 12;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 12;

	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam logic [IMG_W_BITS-1:0] IMG_W_RESET = 6'd5;
	localparam logic [IMG_H_BITS-1:0] IMG_H_RESET = 12'd5;

	// smallest frame side the marker works on
	localparam int MIN_SIDE = 3;

	// depth of the queue between front and back
	localparam int CMDQ_DEPTH = 4;

	// one request from the front to the back
	typedef struct packed {
		logic has_mark;  // emit one mark result
		logic mark;      // value of that mark
		logic flush;     // frame ends here: emit the last row of zero marks
	} cmd_t;

endpackage

@@ rtl/lm4n_ram.sv @@
// generic single write port ram with registered read
module lm4n_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/lm4n_front.sv @@
// front part: sample intake, raster counters, line stores, window and compare
module lm4n_front
	import lm4n_pkg::*;
#(
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] sample_value,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [CFG_DATA_BITS-1:0]      cfg_data,
	input  logic                          q_full,
	output logic                          cmd_push,
	output cmd_t                          cmd,
	output logic [$clog2(MAX_WIDTH+1)-1:0] eff_width
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int SB = SAMPLE_BITS;

	logic [IMG_W_BITS-1:0] image_width_q;
	logic [IMG_H_BITS-1:0] image_height_q;
	logic [IMG_H_BITS-1:0] eff_height;
	logic [AW-1:0]         col_q;
	logic [IMG_H_BITS-1:0] row_q;
	logic                  last_col;
	logic                  last_row;
	logic                  accept;
	logic                  s1_leave;
	logic                  need_cmd;

	logic                  s1_valid_q;
	logic signed [SB-1:0]  x_s1;
	logic [AW-1:0]         col_s1;
	logic                  has_mark_s1;
	logic                  mark_ok_s1;
	logic                  flush_s1;

	logic [2*SB-1:0]       ram_rdata;
	logic signed [SB-1:0]  older_s1;
	logic signed [SB-1:0]  newer_s1;
	logic signed [SB-1:0]  win_q [6];
	logic                  is_max;

	// effective frame size, out-of-range values clamped
	always_comb begin
		if (int'(image_width_q) < MIN_SIDE) begin
			eff_width = CW'(MIN_SIDE);
		end else if (int'(image_width_q) > MAX_WIDTH) begin
			eff_width = CW'(MAX_WIDTH);
		end else begin
			eff_width = CW'(image_width_q);
		end
		if (int'(image_height_q) < MIN_SIDE) begin
			eff_height = IMG_H_BITS'(MIN_SIDE);
		end else begin
			eff_height = image_height_q;
		end
	end

	assign last_col = (CW'(col_q) == eff_width - CW'(1));
	assign last_row = (row_q == eff_height - IMG_H_BITS'(1));

	// intake handshake
	assign need_cmd = has_mark_s1 | flush_s1;
	assign s1_leave = s1_valid_q & (~need_cmd | ~q_full);
	assign full     = s1_valid_q & ~s1_leave;
	assign accept   = push & ~full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMG_W_RESET;
			image_height_q <= IMG_H_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[IMG_W_BITS-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[IMG_H_BITS-1:0];
				default: ;
			endcase
		end
	end

	// raster position of the next sample; a register write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we && (cfg_index == REG_IMAGE_WIDTH ||
				cfg_index == REG_IMAGE_HEIGHT)) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + IMG_H_BITS'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_leave) begin
			s1_valid_q <= 1'b0;
		end
	end

	// stage 1 payload: sample and its classification
	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1        <= sample_value;
			col_s1      <= col_q;
			has_mark_s1 <= (row_q >= IMG_H_BITS'(2)) ||
				(row_q == IMG_H_BITS'(1) && col_q != '0);
			mark_ok_s1  <= (row_q >= IMG_H_BITS'(2)) && (col_q >= AW'(2));
			flush_s1    <= last_col & last_row;
		end
	end

	// line stores: older row in the upper half, newer row in the lower half
	lm4n_ram #(
		.WIDTH(2 * SB),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (s1_leave),
		.waddr(col_s1),
		.wdata({newer_s1, x_s1}),
		.re   (accept),
		.raddr(col_q),
		.rdata(ram_rdata)
	);

	assign older_s1 = ram_rdata[2*SB-1:SB];
	assign newer_s1 = ram_rdata[SB-1:0];

	// window: [0..2] previous column (up, centre, down), [3..5] the one before
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_leave) begin
			win_q[3] <= win_q[0];
			win_q[4] <= win_q[1];
			win_q[5] <= win_q[2];
			win_q[0] <= older_s1;
			win_q[1] <= newer_s1;
			win_q[2] <= x_s1;
		end
	end

	// centre against up, down, left and right
	assign is_max = (win_q[1] >= win_q[0]) && (win_q[1] >= win_q[2]) &&
		(win_q[1] >= win_q[4]) && (win_q[1] >= newer_s1);

	// request to the back part
	assign cmd_push     = s1_valid_q & need_cmd & ~q_full;
	assign cmd.has_mark = has_mark_s1;
	assign cmd.mark     = mark_ok_s1 & is_max;
	assign cmd.flush    = flush_s1;

	// window slots 3 and 5 are only written by the shift, never read
	logic unused_win;
	assign unused_win = ^{win_q[3], win_q[5]};

endmodule

@@ rtl/lm4n_cmd_fifo.sv @@
// short request queue between the front and the back part
module lm4n_cmd_fifo
	import lm4n_pkg::*;
#(
	parameter int DEPTH = CMDQ_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	output logic full,
	input  logic pop,
	output cmd_t dout,
	output logic empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	cmd_t          ent_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == NW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = ent_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= din;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + NW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

@@ rtl/lm4n_back.sv @@
// back part: turns requests into mark results, expands the end-of-frame flush
module lm4n_back
	import lm4n_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	input  cmd_t                           q_head,
	output logic                           q_pop,
	input  logic [$clog2(MAX_WIDTH+1)-1:0] eff_width,
	output logic                           empty,
	input  logic                           pop,
	output logic                           is_local_max,
	output logic                           frame_last
);

	localparam int CW = $clog2(MAX_WIDTH + 1);

	logic          out_valid_q;
	logic          out_mark_q;
	logic          out_last_q;
	logic [CW-1:0] flush_left_q;
	logic          slot_free;
	logic          busy;

	assign slot_free = ~out_valid_q | pop;
	assign busy      = (flush_left_q != '0);
	assign q_pop     = slot_free & ~busy & ~q_empty;

	// output register and flush counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			flush_left_q <= '0;
		end else if (slot_free) begin
			if (busy) begin
				out_valid_q  <= 1'b1;
				flush_left_q <= flush_left_q - CW'(1);
			end else if (!q_empty) begin
				out_valid_q <= q_head.has_mark;
				if (q_head.flush) begin
					flush_left_q <= eff_width;
				end
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (busy) begin
				out_mark_q <= 1'b0;
				out_last_q <= (flush_left_q == CW'(1));
			end else begin
				out_mark_q <= q_head.mark;
				out_last_q <= 1'b0;
			end
		end
	end

	assign empty        = ~out_valid_q;
	assign is_local_max = out_mark_q;
	assign frame_last   = out_last_q;

endmodule

@@ rtl/local_max_4_neighbour_map.sv @@
// top level of the 4-neighbour local maximum marker
// Samples of a frame enter in raster order, one per clock while full is low, and each
// produces a 1-bit mark that says whether the sample is an interior point at least as
// large as its up, down, left and right neighbours; border samples are marked 0. The
// mark of a sample is released when the sample W+1 places later is accepted (W is the
// effective image width) and reaches the result ports through the stage 1 register,
// the request queue and the output register. The last sample of a frame also releases
// the W marks of the last row, frame_last set on the final one; the back part puts
// those out one per clock while results are taken, and meanwhile the first W+1 samples
// of the next frame need no request, so the front never waits on them. Throughput is
// set by the single port pair of the line store ram, one read and one write per sample.
// Writing either register restarts the frame; width is clamped to 3..MAX_WIDTH and
// height to at least 3. Line stores need no clearing after reset.
module local_max_4_neighbour_map
	import lm4n_pkg::*;
#(
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] sample_value,
	output logic                          empty,
	input  logic                          pop,
	output logic                          is_local_max,
	output logic                          frame_last,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH + 1);

	cmd_t          front_cmd;
	logic          front_push;
	logic          q_full;
	logic          q_empty;
	logic          q_pop;
	cmd_t          q_head;
	logic [CW-1:0] eff_width;

	// intake, line stores and compare
	lm4n_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.sample_value(sample_value),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_full      (q_full),
		.cmd_push    (front_push),
		.cmd         (front_cmd),
		.eff_width   (eff_width)
	);

	// request queue
	lm4n_cmd_fifo #(
		.DEPTH(CMDQ_DEPTH)
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (front_push),
		.din   (front_cmd),
		.full  (q_full),
		.pop   (q_pop),
		.dout  (q_head),
		.empty (q_empty)
	);

	// result generation
	lm4n_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.eff_width   (eff_width),
		.empty       (empty),
		.pop         (pop),
		.is_local_max(is_local_max),
		.frame_last  (frame_last)
	);

endmodule

@@ rtl/lm4n_checker.sv @@
// port-level checker of the local maximum marker and its bind
module lm4n_checker (
	input logic clk,
	input logic arst_n,
	input logic full,
	input logic empty,
	input logic pop,
	input logic is_local_max,
	input logic frame_last
);

	// a waiting result holds until taken
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(is_local_max) && $stable(frame_last)))
		else $error("waiting result changed before pop");

	// the frame's final mark lies on the border
	a_last_is_border: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_last) |-> !is_local_max)
		else $error("end-of-frame mark set as local maximum");

	// two frame ends never follow each other directly
	a_no_double_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && frame_last) |=> !(!empty && frame_last))
		else $error("back-to-back end-of-frame results");

	// nothing to deliver and room for a request right after reset
	a_empty_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> (empty && !full))
		else $error("result shown or intake blocked right after reset");

endmodule

bind local_max_4_neighbour_map lm4n_checker u_lm4n_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.full        (full),
	.empty       (empty),
	.pop         (pop),
	.is_local_max(is_local_max),
	.frame_last  (frame_last)
);

@@ tb/sv/tb.sv @@
// self-checking testbench of the 4-neighbour local maximum marker
module tb;
	import lm4n_pkg::*;

	localparam int SB = DEF_SAMPLE_BITS;
	localparam int MW = DEF_MAX_WIDTH;

	// register indexes the block does not decode
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

	// quiet cycles after the last mark, and cycles without any request before giving up
	localparam int SETTLE_CYCLES = 10;
	localparam int STALL_LIMIT   = 2000;

	typedef logic signed [SB-1:0] sample_t;

	typedef struct packed {
		logic mark;
		logic last;
	} mark_rec_t;

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     push         = 1'b0;
	logic                     full;
	sample_t                  sample_value = '0;
	logic                     empty;
	logic                     pop          = 1'b0;
	logic                     is_local_max;
	logic                     frame_last;
	logic                     cfg_we       = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index    = REG_IMAGE_WIDTH;
	logic [CFG_DATA_BITS-1:0] cfg_data     = '0;

	// samples waiting to be sent and marks waiting to come back
	sample_t   samples_pending[$];
	mark_rec_t marks_due[$];

	// predictor state: registers, line stores, 3x2 window, raster position
	logic [IMG_W_BITS-1:0] width_reg = IMG_W_RESET;
	logic [IMG_H_BITS-1:0] height_reg = IMG_H_RESET;
	sample_t older_line[MW];
	sample_t newer_line[MW];
	sample_t win[6] = '{default: '0};
	int      col_at = 0;
	int      row_at = 0;

	int   error_count = 0;
	int   idle_cycles = 0;
	logic push_taken  = 1'b0;
	int   send_rest_pct = 0;
	int   recv_rest_pct = 0;
	int   calm_left = 0;

	wire sample_taken = push && !full;
	wire mark_taken   = pop && !empty;

	local_max_4_neighbour_map i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.sample_value (sample_value),
		.empty        (empty),
		.pop          (pop),
		.is_local_max (is_local_max),
		.frame_last   (frame_last),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// effective frame geometry after clamping
	function automatic int frame_cols();
		if (width_reg < MIN_SIDE) return MIN_SIDE;
		if (width_reg > MW) return MW;
		return int'(width_reg);
	endfunction

	function automatic int frame_rows();
		if (height_reg < MIN_SIDE) return MIN_SIDE;
		return int'(height_reg);
	endfunction

	// register write; a decoded index restarts the frame
	function automatic void apply_reg(logic [CFG_IDX_BITS-1:0] idx,
			logic [CFG_DATA_BITS-1:0] data);
		if (idx == REG_IMAGE_WIDTH) begin
			width_reg = data[IMG_W_BITS-1:0];
			col_at = 0;
			row_at = 0;
		end else if (idx == REG_IMAGE_HEIGHT) begin
			height_reg = data[IMG_H_BITS-1:0];
			col_at = 0;
			row_at = 0;
		end
	endfunction

	// marks released by one accepted sample
	function automatic void mark_sample(sample_t x);
		int        w;
		int        h;
		int        c;
		int        r;
		sample_t   up_row;
		sample_t   mid_row;
		mark_rec_t rec;
		w = frame_cols();
		h = frame_rows();
		c = (col_at >= w) ? w - 1 : col_at;
		r = row_at;
		up_row  = older_line[c];
		mid_row = newer_line[c];

		// mark of the sample W+1 places back, centre held in the window
		if (r >= 2 || (r == 1 && c >= 1)) begin
			rec.mark = 1'b0;
			rec.last = 1'b0;
			if (c >= 2 && r >= 2 && r + 1 <= h && c + 1 <= w)
				rec.mark = (win[1] >= win[0]) && (win[1] >= win[2]) &&
					(win[1] >= win[4]) && (win[1] >= mid_row);
			marks_due.push_back(rec);
		end

		// shift the window and refresh the line stores
		win[3] = win[0];
		win[4] = win[1];
		win[5] = win[2];
		win[0] = up_row;
		win[1] = mid_row;
		win[2] = x;
		older_line[c] = mid_row;
		newer_line[c] = x;

		// last sample of the frame flushes the last row as zero marks
		if (c + 1 >= w && r + 1 >= h) begin
			for (int k = 0; k < w; k++) begin
				rec.mark = 1'b0;
				rec.last = (k + 1 == w);
				marks_due.push_back(rec);
			end
			col_at = 0;
			row_at = 0;
		end else if (c + 1 >= w) begin
			col_at = 0;
			row_at = r + 1;
		end else begin
			col_at = c + 1;
		end
	endfunction

	// compare one returned mark with the oldest one due
	function automatic void check_mark();
		mark_rec_t due;
		if (marks_due.size() == 0) begin
			$error("mark with no request pending: is_local_max %0b frame_last %0b",
				is_local_max, frame_last);
			error_count++;
		end else begin
			due = marks_due.pop_front();
			if (is_local_max !== due.mark) begin
				$error("is_local_max: expected %0b, got %0b", due.mark, is_local_max);
				error_count++;
			end
			if (frame_last !== due.last) begin
				$error("frame_last: expected %0b, got %0b", due.last, frame_last);
				error_count++;
			end
		end
	endfunction

	// random rest decision, suppressed during calm stretches
	function automatic bit rests(int pct);
		return calm_left == 0 && $urandom_range(0, 99) < pct;
	endfunction

	// sample values: mostly a narrow band so that ties and maxima are common
	function automatic sample_t draw_sample();
		int v;
		if ($urandom_range(0, 9) < 7) begin
			v = int'($urandom_range(0, 6)) - 3;
			return v[SB-1:0];
		end
		return SB'($urandom());
	endfunction

	// monitor: takes requests on both sides and register writes
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				apply_reg(cfg_index, cfg_data);
			if (sample_taken)
				mark_sample(sample_value);
			if (mark_taken)
				check_mark();
			push_taken <= sample_taken;
			idle_cycles <= (sample_taken || mark_taken || cfg_we) ? 0 : idle_cycles + 1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// driver: sample requests from the pending queue, pop with random stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (!push || push_taken) begin
				if (samples_pending.size() != 0 && !rests(send_rest_pct)) begin
					push <= 1'b1;
					sample_value <= samples_pending.pop_front();
				end else begin
					push <= 1'b0;
				end
			end
			pop <= !rests(recv_rest_pct);
			if (calm_left > 0)
				calm_left <= calm_left - 1;
			else if ($urandom_range(0, 63) == 0)
				calm_left <= 20;
		end
	end

	// one register write between phases, ends on a rising edge
	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// wait until every sample is sent and every mark has come back
	task automatic settle();
		do
			@(posedge clk);
		while (samples_pending.size() != 0 || push || marks_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// stimulus sequence
	initial begin
		sample_t flat_b[9];
		int      w;
		int      h;
		int      n;
		int      part;
		int      wsel;
		flat_b = '{16'sd32767, 16'sd100, 16'sd32767,
			16'sd100, 16'sd100, 16'sd99,
			16'sd32767, -16'sd5, 16'sd32767};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest frame, width and height below range clamp to 3
		write_reg(REG_IMAGE_WIDTH, 12'hFC2);
		write_reg(REG_IMAGE_HEIGHT, 12'h000);

		// single maximum at the centre against the most negative neighbours
		for (int k = 0; k < 9; k++)
			samples_pending.push_back(k == 4 ? 16'sh7FFF : 16'sh8000);

		// centre ties with two neighbours; undecoded writes mid-frame keep the position
		for (int k = 0; k < 4; k++)
			samples_pending.push_back(flat_b[k]);
		settle();
		write_reg(REG_SPARE_A, 12'hFFF);
		write_reg(REG_SPARE_B, 12'h555);
		for (int k = 4; k < 9; k++)
			samples_pending.push_back(flat_b[k]);
		settle();

		// widest and tallest settings, broken off by the next write
		write_reg(REG_IMAGE_WIDTH, 12'h03F);
		write_reg(REG_IMAGE_HEIGHT, 12'hFFF);
		for (int k = 0; k < 5; k++)
			samples_pending.push_back(SB'($urandom()));
		settle();

		// random frames under each idling pattern
		for (int p = 0; p < 4; p++) begin
			if (p == 0) begin
				write_reg(REG_IMAGE_WIDTH, {6'($urandom()), 6'(MW)});
				write_reg(REG_IMAGE_HEIGHT, 12'd3);
			end else begin
				wsel = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
				write_reg(REG_IMAGE_WIDTH, {6'($urandom()), 6'(wsel)});
				write_reg(REG_IMAGE_HEIGHT, 12'($urandom_range(3, 6)));
			end
			case (p)
				0: begin
					send_rest_pct = 0;
					recv_rest_pct = 0;
				end
				1: begin
					send_rest_pct = 83;
					recv_rest_pct = 0;
				end
				2: begin
					send_rest_pct = 0;
					recv_rest_pct = 83;
				end
				default: begin
					send_rest_pct = 36;
					recv_rest_pct = 36;
				end
			endcase
			w = frame_cols();
			h = frame_rows();
			n = 0;
			while (n < 20) begin
				for (int k = 0; k < w * h; k++)
					samples_pending.push_back(draw_sample());
				n += w * h;
			end
			// sometimes a frame cut short by the next phase's register write
			if ($urandom_range(0, 1) == 1) begin
				part = $urandom_range(1, w * h - 1);
				for (int k = 0; k < part; k++)
					samples_pending.push_back(draw_sample());
			end
			settle();
		end

		if (error_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/lm4n_pkg.sv
rtl/lm4n_ram.sv
rtl/lm4n_front.sv
rtl/lm4n_cmd_fifo.sv
rtl/lm4n_back.sv
rtl/local_max_4_neighbour_map.sv
rtl/lm4n_checker.sv
tb/sv/tb.sv
